[rtl/dual_serial_adc_readout_macros.svh]
// assertion macros shared by the readout modules
`ifndef DUAL_SERIAL_ADC_READOUT_MACROS_SVH
`define DUAL_SERIAL_ADC_READOUT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DSAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DSAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dsar_pkg.sv]
// shared types, constants and codes of the dual-lane serial adc readout
package dsar_pkg;

    localparam int SAMPLE_BITS = 14;
    localparam int VALUE_W     = 14;
    localparam int BIT_CNT_W   = 4;
    localparam int TICK_W      = 8;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [BIT_CNT_W:0] SAMPLE_BITS_C = (BIT_CNT_W+1)'(SAMPLE_BITS);

    // transfer modes
    localparam logic [MODE_W-1:0] MODE_A_LOW  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_A_HIGH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_B_LOW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_B_HIGH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAIR   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONVERT_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUMMY_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_GAP    = 3'd4;

    localparam logic [TICK_W-1:0] CONVERT_LOW_RST = 8'd20;
    localparam logic [TICK_W-1:0] DUMMY_GAP_RST   = 8'd10;
    localparam logic [TICK_W-1:0] EDGE_RST        = 8'd5;
    localparam logic [TICK_W-1:0] CLOCK_HIGH_RST  = 8'd10;
    localparam logic [TICK_W-1:0] PAIR_GAP_RST    = 8'd20;

    typedef struct packed {
        logic [TICK_W-1:0] convert_low_ticks;
        logic [TICK_W-1:0] dummy_gap_ticks;
        logic [TICK_W-1:0] edge_ticks;
        logic [TICK_W-1:0] clock_high_ticks;
        logic [TICK_W-1:0] pair_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic               convert_n;
        logic               chip_select_n;
        logic               serial_clock;
        logic               channel_select;
        logic               idle;
        logic               done_res;
        logic [VALUE_W-1:0] value_first_a;
        logic [VALUE_W-1:0] value_second_a;
        logic [VALUE_W-1:0] value_first_b;
        logic [VALUE_W-1:0] value_second_b;
    } res_t;

endpackage

[rtl/dsar_cfg.sv]
// timing configuration registers
module dsar_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsar_pkg::TICK_W-1:0]    cfg_data,
    output dsar_pkg::cfg_t                 cfg
);
    import dsar_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.convert_low_ticks <= CONVERT_LOW_RST;
            cfg_reg.dummy_gap_ticks   <= DUMMY_GAP_RST;
            cfg_reg.edge_ticks        <= EDGE_RST;
            cfg_reg.clock_high_ticks  <= CLOCK_HIGH_RST;
            cfg_reg.pair_gap_ticks    <= PAIR_GAP_RST;
        end else if (cfg_valid) begin
            // indexes past the list are dropped
            unique case (cfg_index)
                REG_CONVERT_LOW: cfg_reg.convert_low_ticks <= cfg_data;
                REG_DUMMY_GAP:   cfg_reg.dummy_gap_ticks   <= cfg_data;
                REG_EDGE:        cfg_reg.edge_ticks        <= cfg_data;
                REG_CLOCK_HIGH:  cfg_reg.clock_high_ticks  <= cfg_data;
                REG_PAIR_GAP:    cfg_reg.pair_gap_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/dsar_seq.sv]
// pin sequencer: one tick of the conversion and shift-in sequence per item
module dsar_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        start_req,
    input  logic [dsar_pkg::MODE_W-1:0] mode,
    input  logic                        busy_req,
    input  logic                        dout_a,
    input  logic                        dout_b,
    input  dsar_pkg::cfg_t              cfg,
    output dsar_pkg::res_t              res
);
    import dsar_pkg::*;

    `include "dual_serial_adc_readout_macros.svh"

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_DUMMY_LOW  = 4'd1;
    localparam logic [3:0] PH_DUMMY_GAP  = 4'd2;
    localparam logic [3:0] PH_CONV_LOW   = 4'd3;
    localparam logic [3:0] PH_WAIT_BUSY  = 4'd4;
    localparam logic [3:0] PH_CS_SETUP   = 4'd5;
    localparam logic [3:0] PH_CLK_HIGH   = 4'd6;
    localparam logic [3:0] PH_LOW1       = 4'd7;
    localparam logic [3:0] PH_LOW2       = 4'd8;
    localparam logic [3:0] PH_CS_HOLD    = 4'd9;
    localparam logic [3:0] PH_PAIR_GAP   = 4'd10;

    logic [3:0]           phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic                 second_reg, second_next;
    logic [VALUE_W-1:0]   shift_a_reg, shift_a_next;
    logic [VALUE_W-1:0]   shift_b_reg, shift_b_next;
    logic [VALUE_W-1:0]   fa_reg, fa_next, sa_reg, sa_next;
    logic [VALUE_W-1:0]   fb_reg, fb_next, sb_reg, sb_next;
    logic                 conv_reg, conv_next;
    logic                 cs_reg, cs_next;
    logic                 clk_reg, clk_next;
    logic                 sel_reg, sel_next;
    logic                 done;
    logic [TICK_W-1:0]    limit;
    logic                 over;
    logic                 bit_last;

    // tick budget of the current phase
    always_comb begin
        unique case (phase_reg)
            PH_DUMMY_LOW, PH_CONV_LOW:                 limit = cfg.convert_low_ticks;
            PH_DUMMY_GAP:                              limit = cfg.dummy_gap_ticks;
            PH_CS_SETUP, PH_LOW1, PH_LOW2, PH_CS_HOLD: limit = cfg.edge_ticks;
            PH_CLK_HIGH:                               limit = cfg.clock_high_ticks;
            PH_PAIR_GAP:                               limit = cfg.pair_gap_ticks;
            default:                                   limit = cfg.convert_low_ticks;
        endcase
    end

    // a zero budget behaves as one since entry already counts one tick
    assign over     = (tick_reg >= limit);
    assign bit_last = (({1'b0, bit_reg} + 5'd1) >= SAMPLE_BITS_C);

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = over ? tick_reg : tick_reg + 8'd1;
        bit_next     = bit_reg;
        mode_next    = mode_reg;
        second_next  = second_reg;
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        fa_next      = fa_reg;
        sa_next      = sa_reg;
        fb_next      = fb_reg;
        sb_next      = sb_reg;
        conv_next    = conv_reg;
        cs_next      = cs_reg;
        clk_next     = clk_reg;
        sel_next     = sel_reg;
        done         = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                tick_next = tick_reg;
                if (start_req && mode <= MODE_PAIR) begin
                    mode_next   = mode;
                    second_next = 1'b0;
                    sel_next    = (mode == MODE_A_HIGH) || (mode == MODE_B_HIGH);
                    cs_next     = 1'b1;
                    clk_next    = 1'b1;
                    conv_next   = 1'b0;
                    phase_next  = PH_DUMMY_LOW;
                    tick_next   = 8'd1;
                end
            end
            PH_DUMMY_LOW: begin
                if (over) begin
                    conv_next  = 1'b1;
                    phase_next = PH_DUMMY_GAP;
                    tick_next  = 8'd1;
                end
            end
            PH_DUMMY_GAP: begin
                if (over) begin
                    if (mode_reg == MODE_PAIR) begin
                        sel_next = 1'b1;
                    end
                    conv_next  = 1'b0;
                    phase_next = PH_CONV_LOW;
                    tick_next  = 8'd1;
                end
            end
            PH_CONV_LOW: begin
                if (over) begin
                    conv_next  = 1'b1;
                    phase_next = PH_WAIT_BUSY;
                    tick_next  = 8'd1;
                end
            end
            PH_WAIT_BUSY: begin
                tick_next = tick_reg;
                if (!busy_req) begin
                    phase_next = PH_CS_SETUP;
                    tick_next  = 8'd1;
                end
            end
            PH_CS_SETUP: begin
                if (over) begin
                    cs_next      = 1'b0;
                    bit_next     = '0;
                    shift_a_next = '0;
                    shift_b_next = '0;
                    phase_next   = PH_CLK_HIGH;
                    tick_next    = 8'd1;
                end
            end
            PH_CLK_HIGH: begin
                if (over) begin
                    clk_next   = 1'b0;
                    phase_next = PH_LOW1;
                    tick_next  = 8'd1;
                end
            end
            PH_LOW1: begin
                // sample both lanes at the middle of clock low
                if (over) begin
                    shift_a_next = {shift_a_reg[VALUE_W-2:0], dout_a};
                    shift_b_next = {shift_b_reg[VALUE_W-2:0], dout_b};
                    phase_next   = PH_LOW2;
                    tick_next    = 8'd1;
                end
            end
            PH_LOW2: begin
                if (over) begin
                    clk_next  = 1'b1;
                    tick_next = 8'd1;
                    if (bit_last) begin
                        bit_next   = '0;
                        phase_next = PH_CS_HOLD;
                    end else begin
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_CLK_HIGH;
                    end
                end
            end
            PH_CS_HOLD: begin
                if (over) begin
                    cs_next = 1'b1;
                    unique case (mode_reg)
                        MODE_A_LOW:  fa_next = shift_a_reg;
                        MODE_A_HIGH: sa_next = shift_a_reg;
                        MODE_B_LOW:  fb_next = shift_b_reg;
                        MODE_B_HIGH: sb_next = shift_b_reg;
                        default: begin
                            if (second_reg) begin
                                sa_next = shift_a_reg;
                                sb_next = shift_b_reg;
                            end else begin
                                fa_next = shift_a_reg;
                                fb_next = shift_b_reg;
                            end
                        end
                    endcase
                    if (mode_reg == MODE_PAIR && !second_reg) begin
                        second_next = 1'b1;
                        phase_next  = PH_PAIR_GAP;
                        tick_next   = 8'd1;
                    end else begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                end
            end
            PH_PAIR_GAP: begin
                if (over) begin
                    conv_next  = 1'b0;
                    phase_next = PH_CONV_LOW;
                    tick_next  = 8'd1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            mode_reg   <= '0;
            second_reg <= 1'b0;
            fa_reg     <= '0;
            sa_reg     <= '0;
            fb_reg     <= '0;
            sb_reg     <= '0;
            conv_reg   <= 1'b1;
            cs_reg     <= 1'b1;
            clk_reg    <= 1'b1;
            sel_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            mode_reg   <= mode_next;
            second_reg <= second_next;
            fa_reg     <= fa_next;
            sa_reg     <= sa_next;
            fb_reg     <= fb_next;
            sb_reg     <= sb_next;
            conv_reg   <= conv_next;
            cs_reg     <= cs_next;
            clk_reg    <= clk_next;
            sel_reg    <= sel_next;
        end
    end

    // shift registers are cleared before every read
    always_ff @(posedge aclk) begin
        if (advance) begin
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
        end
    end

    assign res.convert_n      = conv_next;
    assign res.chip_select_n  = cs_next;
    assign res.serial_clock   = clk_next;
    assign res.channel_select = sel_next;
    assign res.idle           = (phase_next == PH_IDLE);
    assign res.done_res       = done;
    assign res.value_first_a  = fa_next;
    assign res.value_second_a = sa_next;
    assign res.value_first_b  = fb_next;
    assign res.value_second_b = sb_next;

    `DSAR_ASSERT_NOW(a_cs_only_in_read, !cs_reg,
        phase_reg == PH_CLK_HIGH || phase_reg == PH_LOW1 ||
        phase_reg == PH_LOW2 || phase_reg == PH_CS_HOLD,
        "chip select low outside the read phases")
    `DSAR_ASSERT_NOW(a_clk_low_phase, !clk_reg,
        phase_reg == PH_LOW1 || phase_reg == PH_LOW2,
        "serial clock low outside the clock-low phases")
    `DSAR_ASSERT_NOW(a_bit_range, 1'b1, bit_reg < SAMPLE_BITS_C[BIT_CNT_W-1:0] ||
        SAMPLE_BITS_C[BIT_CNT_W],
        "bit counter past the sample length")
    `DSAR_ASSERT_NEXT(a_done_to_idle, advance && done,
        phase_reg == PH_IDLE && cs_reg && conv_reg,
        "completed transfer did not return to idle with lines high")

endmodule

[rtl/dsar_skid.sv]
// result register with a skid stage so input can take one more item under output stall
module dsar_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dsar_pkg::res_t push_data,
    output logic           push_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output dsar_pkg::res_t m_data
);
    import dsar_pkg::*;

    `include "dual_serial_adc_readout_macros.svh"

    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic pop;

    assign pop        = out_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= push_data;
            end else begin
                out_reg <= push_data;
            end
        end
    end

    `DSAR_ASSERT_NOW(a_skid_implies_out, skid_valid_reg, out_valid_reg,
        "skid stage holds an item while the output register is empty")
    `DSAR_ASSERT_NEXT(a_stall_to_skid, push && out_valid_reg && !m_ready,
        skid_valid_reg && out_valid_reg,
        "item pushed under output stall was not kept")

endmodule

[rtl/dual_serial_adc_readout.sv]
// top level of the dual-lane serial adc readout sequencer
// each accepted item's result is registered in the output stage (skid entry under a stall)
// throughput: one item (one tick) per cycle while s_ready is high; a two-entry output
// stage keeps s_ready high for one extra item while the result side stalls
// reset (aresetn low, synchronous): idle, convert/chip select/clock high, select low,
// stored readings zero, timing registers at their defaults
module dual_serial_adc_readout (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_req,
    input  logic [dsar_pkg::MODE_W-1:0]    s_mode,
    input  logic                           s_busy_req,
    input  logic                           s_dout_a,
    input  logic                           s_dout_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_convert_n,
    output logic                           m_chip_select_n,
    output logic                           m_serial_clock,
    output logic                           m_channel_select,
    output logic                           m_idle,
    output logic                           m_done_res,
    output logic [dsar_pkg::VALUE_W-1:0]   m_value_first_a,
    output logic [dsar_pkg::VALUE_W-1:0]   m_value_second_a,
    output logic [dsar_pkg::VALUE_W-1:0]   m_value_first_b,
    output logic [dsar_pkg::VALUE_W-1:0]   m_value_second_b,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsar_pkg::TICK_W-1:0]    cfg_data
);
    import dsar_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t m_data;
    logic advance;

    assign advance = s_valid && s_ready;

    dsar_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsar_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .start_req (s_start_req),
        .mode      (s_mode),
        .busy_req  (s_busy_req),
        .dout_a    (s_dout_a),
        .dout_b    (s_dout_b),
        .cfg       (cfg),
        .res       (res)
    );

    dsar_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (advance),
        .push_data  (res),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_convert_n      = m_data.convert_n;
    assign m_chip_select_n  = m_data.chip_select_n;
    assign m_serial_clock   = m_data.serial_clock;
    assign m_channel_select = m_data.channel_select;
    assign m_idle           = m_data.idle;
    assign m_done_res       = m_data.done_res;
    assign m_value_first_a  = m_data.value_first_a;
    assign m_value_second_a = m_data.value_second_a;
    assign m_value_first_b  = m_data.value_first_b;
    assign m_value_second_b = m_data.value_second_b;

endmodule

[verif/tb_top.sv]
// testbench of the dual-lane serial adc readout sequencer: tick stimulus, pin and reading checks
`timescale 1ns / 1ps

module tb_top;
    import dsar_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_TICKS = 100;
    localparam int TICKS_PER_SETTING = 25;

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    // all lines high, select low, idle, no readings yet
    localparam res_t RES_AT_RESET = res_t'({1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 56'd0});
    // first tick of a lane b select-high transfer: convert drops, select rises
    localparam res_t RES_B_HIGH_START = res_t'({1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 56'd0});

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_DUMMY_LOW, SEQ_DUMMY_GAP, SEQ_CONV_LOW, SEQ_WAIT_BUSY,
        SEQ_CS_SETUP, SEQ_CLK_HIGH, SEQ_LOW1, SEQ_LOW2, SEQ_CS_HOLD, SEQ_PAIR_GAP
    } seq_phase_e;

    typedef struct {
        logic              start;
        logic [MODE_W-1:0] mode;
        logic              busy;
        logic              da;
        logic              db;
        bit                typed;
        res_t              want;
        bit                run_out;
        bit                retime;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_start_req = 1'b0;
    logic [MODE_W-1:0] s_mode = '0;
    logic s_busy_req = 1'b0;
    logic s_dout_a = 1'b0;
    logic s_dout_b = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_convert_n, m_chip_select_n, m_serial_clock, m_channel_select, m_idle, m_done_res;
    logic [VALUE_W-1:0] m_value_first_a, m_value_second_a, m_value_first_b, m_value_second_b;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0] cfg_data = '0;

    // predicted sequencer state
    seq_phase_e         seq_phase;
    logic [TICK_W-1:0]  tick_cnt;
    logic [3:0]         bit_cnt;
    logic [MODE_W-1:0]  run_mode;
    logic               pair_second;
    logic [15:0]        sh_a, sh_b;
    logic [VALUE_W-1:0] rd_first_a, rd_second_a, rd_first_b, rd_second_b;
    logic               pin_conv, pin_cs, pin_clk, pin_sel;
    cfg_t               timing_shadow;

    res_t pending_readouts[$];
    stim_row_t directed_rows[$];

    int mismatches = 0;
    int n_checked = 0;
    int n_done = 0;
    int n_random = 0;
    int n_settings = 1;
    int busy_left = 0;
    int tx_count = 0;
    bit tx_quiet = 1'b0;
    int rx_count = 0;
    bit rx_quiet = 1'b0;
    int rx_hold = 0;
    int stall_cycles = 0;

    dual_serial_adc_readout DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_req      (s_start_req),
        .s_mode           (s_mode),
        .s_busy_req       (s_busy_req),
        .s_dout_a         (s_dout_a),
        .s_dout_b         (s_dout_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_convert_n      (m_convert_n),
        .m_chip_select_n  (m_chip_select_n),
        .m_serial_clock   (m_serial_clock),
        .m_channel_select (m_channel_select),
        .m_idle           (m_idle),
        .m_done_res       (m_done_res),
        .m_value_first_a  (m_value_first_a),
        .m_value_second_a (m_value_second_a),
        .m_value_first_b  (m_value_first_b),
        .m_value_second_b (m_value_second_b),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #4 aclk = ~aclk;
    end

    task automatic reset_predictor();
        seq_phase = SEQ_IDLE;
        tick_cnt = '0;
        bit_cnt = '0;
        run_mode = MODE_A_LOW;
        pair_second = 1'b0;
        sh_a = '0;
        sh_b = '0;
        rd_first_a = '0;
        rd_second_a = '0;
        rd_first_b = '0;
        rd_second_b = '0;
        pin_conv = 1'b1;
        pin_cs = 1'b1;
        pin_clk = 1'b1;
        pin_sel = 1'b0;
        timing_shadow.convert_low_ticks = CONVERT_LOW_RST;
        timing_shadow.dummy_gap_ticks = DUMMY_GAP_RST;
        timing_shadow.edge_ticks = EDGE_RST;
        timing_shadow.clock_high_ticks = CLOCK_HIGH_RST;
        timing_shadow.pair_gap_ticks = PAIR_GAP_RST;
    endtask

    // true once the phase has lasted lim ticks; a limit of zero behaves as one
    function automatic bit span_done(input logic [TICK_W-1:0] lim);
        if (tick_cnt >= lim)
            return 1'b1;
        tick_cnt = tick_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic void go_to(input seq_phase_e p);
        seq_phase = p;
        tick_cnt = 8'd1;
    endfunction

    task automatic store_reading();
        case (run_mode)
            MODE_A_LOW:  rd_first_a = sh_a[VALUE_W-1:0];
            MODE_A_HIGH: rd_second_a = sh_a[VALUE_W-1:0];
            MODE_B_LOW:  rd_first_b = sh_b[VALUE_W-1:0];
            MODE_B_HIGH: rd_second_b = sh_b[VALUE_W-1:0];
            default: begin
                if (pair_second) begin
                    rd_second_a = sh_a[VALUE_W-1:0];
                    rd_second_b = sh_b[VALUE_W-1:0];
                end else begin
                    rd_first_a = sh_a[VALUE_W-1:0];
                    rd_first_b = sh_b[VALUE_W-1:0];
                end
            end
        endcase
    endtask

    task automatic predict_tick(input logic st, input logic [MODE_W-1:0] md, input logic bz,
                                input logic a, input logic b, output res_t r);
        logic done;
        done = 1'b0;
        case (seq_phase)
            SEQ_IDLE: begin
                if (st && md <= MODE_PAIR) begin
                    run_mode = md;
                    pair_second = 1'b0;
                    pin_sel = (md == MODE_A_HIGH || md == MODE_B_HIGH);
                    pin_cs = 1'b1;
                    pin_clk = 1'b1;
                    pin_conv = 1'b0;
                    go_to(SEQ_DUMMY_LOW);
                end
            end
            SEQ_DUMMY_LOW: begin
                if (span_done(timing_shadow.convert_low_ticks)) begin
                    pin_conv = 1'b1;
                    go_to(SEQ_DUMMY_GAP);
                end
            end
            SEQ_DUMMY_GAP: begin
                if (span_done(timing_shadow.dummy_gap_ticks)) begin
                    if (run_mode == MODE_PAIR)
                        pin_sel = 1'b1;
                    pin_conv = 1'b0;
                    go_to(SEQ_CONV_LOW);
                end
            end
            SEQ_CONV_LOW: begin
                if (span_done(timing_shadow.convert_low_ticks)) begin
                    pin_conv = 1'b1;
                    go_to(SEQ_WAIT_BUSY);
                end
            end
            SEQ_WAIT_BUSY: begin
                if (!bz)
                    go_to(SEQ_CS_SETUP);
            end
            SEQ_CS_SETUP: begin
                if (span_done(timing_shadow.edge_ticks)) begin
                    pin_cs = 1'b0;
                    bit_cnt = '0;
                    sh_a = '0;
                    sh_b = '0;
                    go_to(SEQ_CLK_HIGH);
                end
            end
            SEQ_CLK_HIGH: begin
                if (span_done(timing_shadow.clock_high_ticks)) begin
                    pin_clk = 1'b0;
                    go_to(SEQ_LOW1);
                end
            end
            SEQ_LOW1: begin
                // both lanes sampled at the end of the first half of clock low
                if (span_done(timing_shadow.edge_ticks)) begin
                    sh_a = {sh_a[14:0], a};
                    sh_b = {sh_b[14:0], b};
                    go_to(SEQ_LOW2);
                end
            end
            SEQ_LOW2: begin
                if (span_done(timing_shadow.edge_ticks)) begin
                    pin_clk = 1'b1;
                    if (int'(bit_cnt) + 1 >= SAMPLE_BITS) begin
                        bit_cnt = '0;
                        go_to(SEQ_CS_HOLD);
                    end else begin
                        bit_cnt = bit_cnt + 1'b1;
                        go_to(SEQ_CLK_HIGH);
                    end
                end
            end
            SEQ_CS_HOLD: begin
                if (span_done(timing_shadow.edge_ticks)) begin
                    pin_cs = 1'b1;
                    store_reading();
                    if (run_mode == MODE_PAIR && !pair_second) begin
                        pair_second = 1'b1;
                        go_to(SEQ_PAIR_GAP);
                    end else begin
                        done = 1'b1;
                        seq_phase = SEQ_IDLE;
                        tick_cnt = '0;
                    end
                end
            end
            SEQ_PAIR_GAP: begin
                if (span_done(timing_shadow.pair_gap_ticks)) begin
                    pin_conv = 1'b0;
                    go_to(SEQ_CONV_LOW);
                end
            end
            default: begin
                seq_phase = SEQ_IDLE;
                tick_cnt = '0;
            end
        endcase
        if (done)
            n_done++;
        r = {pin_conv, pin_cs, pin_clk, pin_sel, seq_phase == SEQ_IDLE, done,
             rd_first_a, rd_second_a, rd_first_b, rd_second_b};
    endtask

    // mostly well-formed ticks: starts in idle, busy held a while after the real conversion
    task automatic make_tick(output logic st, output logic [MODE_W-1:0] md, output logic bz,
                             output logic a, output logic b);
        if (seq_phase == SEQ_IDLE) begin
            st = ($urandom_range(0, 3) != 0);
            md = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(5, 7))
                                             : MODE_W'($urandom_range(0, 4));
        end else begin
            st = 1'($urandom_range(0, 1));
            md = MODE_W'($urandom_range(0, 7));
        end
        if (seq_phase == SEQ_CONV_LOW)
            busy_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(10, 40))
                                                    : int'($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0) begin
            bz = 1'($urandom_range(0, 1));
        end else if (seq_phase == SEQ_WAIT_BUSY) begin
            bz = (busy_left != 0);
            if (busy_left != 0)
                busy_left--;
        end else begin
            bz = 1'($urandom_range(0, 1));
        end
        a = 1'($urandom_range(0, 1));
        b = 1'($urandom_range(0, 1));
    endtask

    task automatic send_tick(input logic st, input logic [MODE_W-1:0] md, input logic bz,
                             input logic a, input logic b, input bit typed, input res_t want);
        int gap;
        res_t predicted;
        tx_count++;
        if (tx_count % 100 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : int'($urandom_range(0, 4));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_start_req <= st;
        s_mode <= md;
        s_busy_req <= bz;
        s_dout_a <= a;
        s_dout_b <= b;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tick(st, md, bz, a, b, predicted);
        pending_readouts.push_back(typed ? want : predicted);
    endtask

    // feed ticks without start until the sequencer is back in idle
    task automatic finish_transfer(input bit hold_pins, input logic a, input logic b);
        logic st, bz, ra, rb;
        logic [MODE_W-1:0] md;
        while (seq_phase != SEQ_IDLE) begin
            make_tick(st, md, bz, ra, rb);
            if (hold_pins) begin
                ra = a;
                rb = b;
            end
            send_tick(1'b0, md, bz, ra, rb, 1'b0, '0);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_CONVERT_LOW: timing_shadow.convert_low_ticks = d;
            REG_DUMMY_GAP:   timing_shadow.dummy_gap_ticks = d;
            REG_EDGE:        timing_shadow.edge_ticks = d;
            REG_CLOCK_HIGH:  timing_shadow.clock_high_ticks = d;
            REG_PAIR_GAP:    timing_shadow.pair_gap_ticks = d;
            default: ;
        endcase
    endtask

    task automatic load_timing(input cfg_t c, input bit spare);
        write_reg(REG_CONVERT_LOW, c.convert_low_ticks);
        write_reg(REG_DUMMY_GAP, c.dummy_gap_ticks);
        write_reg(REG_EDGE, c.edge_ticks);
        write_reg(REG_CLOCK_HIGH, c.clock_high_ticks);
        write_reg(REG_PAIR_GAP, c.pair_gap_ticks);
        // indexes past the last register must leave the timing alone
        if (spare)
            for (int i = int'(REG_PAIR_GAP) + 1; i < 8; i++)
                write_reg(CFG_IDX_W'(i), TICK_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic add_row(input logic st, input logic [MODE_W-1:0] md, input logic bz,
                           input logic a, input logic b, input bit typed, input res_t want,
                           input bit run_out, input bit retime);
        stim_row_t row;
        row.start = st;
        row.mode = md;
        row.busy = bz;
        row.da = a;
        row.db = b;
        row.typed = typed;
        row.want = want;
        row.run_out = run_out;
        row.retime = retime;
        directed_rows.push_back(row);
    endtask

    task automatic check_readout();
        res_t want;
        if (pending_readouts.size() == 0) begin
            $error("result arrived with no item waiting");
            mismatches++;
        end else begin
            want = pending_readouts.pop_front();
            if (m_convert_n !== want.convert_n) begin
                $error("convert_n: expected %0d, actual %0d", want.convert_n, m_convert_n);
                mismatches++;
            end
            if (m_chip_select_n !== want.chip_select_n) begin
                $error("chip_select_n: expected %0d, actual %0d",
                       want.chip_select_n, m_chip_select_n);
                mismatches++;
            end
            if (m_serial_clock !== want.serial_clock) begin
                $error("serial_clock: expected %0d, actual %0d",
                       want.serial_clock, m_serial_clock);
                mismatches++;
            end
            if (m_channel_select !== want.channel_select) begin
                $error("channel_select: expected %0d, actual %0d",
                       want.channel_select, m_channel_select);
                mismatches++;
            end
            if (m_idle !== want.idle) begin
                $error("idle: expected %0d, actual %0d", want.idle, m_idle);
                mismatches++;
            end
            if (m_done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, m_done_res);
                mismatches++;
            end
            if (m_value_first_a !== want.value_first_a) begin
                $error("value_first_a: expected %0h, actual %0h",
                       want.value_first_a, m_value_first_a);
                mismatches++;
            end
            if (m_value_second_a !== want.value_second_a) begin
                $error("value_second_a: expected %0h, actual %0h",
                       want.value_second_a, m_value_second_a);
                mismatches++;
            end
            if (m_value_first_b !== want.value_first_b) begin
                $error("value_first_b: expected %0h, actual %0h",
                       want.value_first_b, m_value_first_b);
                mismatches++;
            end
            if (m_value_second_b !== want.value_second_b) begin
                $error("value_second_b: expected %0h, actual %0h",
                       want.value_second_b, m_value_second_b);
                mismatches++;
            end
        end
        n_checked++;
    endtask

    // result side: ready is dropped after most items and raised again when the random hold runs out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            check_readout();
            rx_count++;
            if (rx_count % 100 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            if (!rx_quiet && $urandom_range(0, 4) != 0) begin
                m_ready <= 1'b0;
                rx_hold <= int'($urandom_range(1, 4));
            end
        end else if (!m_ready) begin
            if (rx_hold > 1)
                rx_hold <= rx_hold - 1;
            else
                m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic st, bz, a, b;
        logic [MODE_W-1:0] md;
        cfg_t timing;
        int pass_no;

        reset_predictor();
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, first at the reset timing
        add_row(1'b0, MODE_A_LOW, 1'b0, 1'b0, 1'b0, 1'b1, RES_AT_RESET, 1'b0, 1'b0);
        add_row(1'b1, MODE_UNUSED_5, 1'b0, 1'b1, 1'b0, 1'b1, RES_AT_RESET, 1'b0, 1'b0);
        add_row(1'b1, MODE_UNUSED_6, 1'b1, 1'b1, 1'b1, 1'b1, RES_AT_RESET, 1'b0, 1'b0);
        add_row(1'b1, MODE_UNUSED_7, 1'b1, 1'b0, 1'b1, 1'b1, RES_AT_RESET, 1'b0, 1'b0);
        add_row(1'b0, MODE_PAIR, 1'b1, 1'b1, 1'b1, 1'b1, RES_AT_RESET, 1'b0, 1'b0);
        add_row(1'b1, MODE_B_HIGH, 1'b0, 1'b0, 1'b0, 1'b1, RES_B_HIGH_START, 1'b0, 1'b0);
        // starts while a transfer runs are ignored
        add_row(1'b1, MODE_A_LOW, 1'b0, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(1'b1, MODE_PAIR, 1'b1, 1'b0, 1'b1, 1'b0, '0, 1'b1, 1'b0);
        // one-tick timing, data pins held constant: all-ones and all-zero readings
        add_row(1'b1, MODE_PAIR, 1'b0, 1'b1, 1'b1, 1'b0, '0, 1'b1, 1'b1);
        add_row(1'b1, MODE_A_LOW, 1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b1, 1'b0);
        add_row(1'b1, MODE_B_HIGH, 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b1, 1'b0);
        add_row(1'b0, MODE_A_LOW, 1'b1, 1'b1, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].retime) begin
                settle();
                load_timing({5{8'd1}}, 1'b0);
            end
            send_tick(directed_rows[i].start, directed_rows[i].mode, directed_rows[i].busy,
                      directed_rows[i].da, directed_rows[i].db, directed_rows[i].typed,
                      directed_rows[i].want);
            if (directed_rows[i].run_out)
                finish_transfer(1'b1, directed_rows[i].da, directed_rows[i].db);
        end
        settle();

        // random part, at short timings so several transfers complete
        pass_no = 0;
        while (n_random < RANDOM_TICKS) begin
            if (pass_no == 0) begin
                timing = {5{8'd1}};
            end else if (pass_no == 1) begin
                timing = '0;
            end else begin
                timing.convert_low_ticks = ($urandom_range(0, 4) == 0) ?
                    TICK_W'($urandom_range(20, 60)) : TICK_W'($urandom_range(1, 6));
                timing.dummy_gap_ticks = ($urandom_range(0, 4) == 0) ?
                    TICK_W'($urandom_range(20, 60)) : TICK_W'($urandom_range(1, 6));
                timing.edge_ticks = TICK_W'($urandom_range(1, 4));
                timing.clock_high_ticks = TICK_W'($urandom_range(1, 6));
                timing.pair_gap_ticks = ($urandom_range(0, 4) == 0) ?
                    TICK_W'($urandom_range(20, 60)) : TICK_W'($urandom_range(1, 6));
            end
            load_timing(timing, pass_no < 2);
            repeat (TICKS_PER_SETTING) begin
                make_tick(st, md, bz, a, b);
                n_random++;
                send_tick(st, md, bz, a, b, 1'b0, '0);
            end
            finish_transfer(1'b0, 1'b0, 1'b0);
            settle();
            pass_no++;
        end
        repeat (8) @(posedge aclk);

        $display("checked %0d ticks, %0d completed transfers, %0d timing settings",
                 n_checked, n_done, n_settings);
        $display("random ticks: %0d, mismatches: %0d", n_random, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
